// ----- src/ssms_pkg.sv -----
// shared constants, codes and types for the stepper step and microstep sequencer
// no dependencies; imported by every module under src
package ssms_pkg;

  localparam int PWM_FULL = 65535;
  localparam int MAX_DIV  = 256;

  localparam int DIV_W     = 9;
  localparam int CNT_W     = 16;
  localparam int TICK_W    = 16;
  localparam int DUTY_W    = 16;
  localparam int IDX_W     = 10;
  localparam int DIV_IDX_W = $clog2(MAX_DIV);
  localparam int ACC_W     = DUTY_W + 2;

  // request kinds
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_FULL  = 2'd1;
  localparam logic [1:0] REQ_MICRO = 2'd2;

  // reported drive mode
  localparam logic [1:0] DRV_IDLE  = 2'd0;
  localparam logic [1:0] DRV_FULL  = 2'd1;
  localparam logic [1:0] DRV_MICRO = 2'd2;

  // stored mode: idle, full-step, otherwise the division in use
  localparam logic [DIV_W-1:0] MODE_IDLE = DIV_W'(0);
  localparam logic [DIV_W-1:0] MODE_FULL = DIV_W'(1);

  typedef logic [3:0][DUTY_W-1:0] duty_vec_t;

  localparam duty_vec_t DUTY_RESET = {DUTY_W'(PWM_FULL), DUTY_W'(0), DUTY_W'(0), DUTY_W'(1)};

  typedef struct packed {
    duty_vec_t        duty;
    logic [IDX_W-1:0] index;
  } ramp_t;

endpackage

// ----- src/ssms_step_rom.sv -----
// duty increment per microstep, PWM_FULL / division, as a constant table
// depends on ssms_pkg
module ssms_step_rom import ssms_pkg::*; (
  input  logic [DIV_W-1:0]  div,
  output logic [DUTY_W-1:0] add
);

  logic [DUTY_W-1:0]    tab [MAX_DIV];
  logic [DIV_W-1:0]     div_m1;

  for (genvar g = 0; g < MAX_DIV; g++) begin : g_tab
    localparam logic [DUTY_W-1:0] STEP = DUTY_W'(PWM_FULL / (g + 1));
    assign tab[g] = STEP;
  end

  // division is already limited to 1..MAX_DIV
  assign div_m1 = div - DIV_W'(1);
  assign add    = tab[div_m1[DIV_IDX_W-1:0]];

endmodule

// ----- src/ssms_ramp.sv -----
// one microstep of the four-channel duty ramp with clamping and index wrap
// depends on ssms_pkg
module ssms_ramp import ssms_pkg::*; (
  input  logic [IDX_W-1:0]  index,
  input  logic [DIV_W-1:0]  div,
  input  logic [DUTY_W-1:0] add,
  input  duty_vec_t         duty_in,
  output ramp_t             ramp
);

  logic [IDX_W:0]           div2;
  logic [IDX_W:0]           div3;
  logic [IDX_W:0]           div4;
  logic [IDX_W:0]           idx_ext;
  logic [IDX_W-1:0]         idx;
  logic [1:0]               quarter;
  logic signed [ACC_W-1:0]  step;
  logic signed [ACC_W-1:0]  acc [4];

  always_comb begin
    div2    = {1'b0, div, 1'b0};
    div3    = div2 + (IDX_W+1)'(div);
    div4    = {div, 2'b00};
    // index left over from another division restarts the cycle
    idx_ext = ((IDX_W+1)'(index) >= div4) ? '0 : (IDX_W+1)'(index);
    idx     = idx_ext[IDX_W-1:0];

    if (idx_ext < (IDX_W+1)'(div))  quarter = 2'd0;
    else if (idx_ext < div2)        quarter = 2'd1;
    else if (idx_ext < div3)        quarter = 2'd2;
    else                            quarter = 2'd3;

    step = signed'({2'b00, add});
    for (int i = 0; i < 4; i++) acc[i] = signed'({2'b00, duty_in[i]});

    case (quarter)
      2'd0: begin
        acc[1] = '0;
        acc[0] = acc[0] + step;
        acc[3] = acc[3] - step;
      end
      2'd1: begin
        acc[3] = '0;
        acc[2] = acc[2] + step;
        acc[0] = acc[0] - step;
      end
      2'd2: begin
        acc[0] = '0;
        acc[2] = acc[2] - step;
        acc[1] = acc[1] + step;
      end
      default: begin
        acc[2] = '0;
        acc[1] = acc[1] - step;
        acc[3] = acc[3] + step;
      end
    endcase

    for (int i = 0; i < 4; i++) begin
      if (acc[i] < 0)                              ramp.duty[i] = '0;
      else if (acc[i] > ACC_W'(PWM_FULL))          ramp.duty[i] = DUTY_W'(PWM_FULL);
      else                                         ramp.duty[i] = acc[i][DUTY_W-1:0];
    end

    if (idx_ext == div4 - (IDX_W+1)'(1)) ramp.index = '0;
    else                                 ramp.index = idx + IDX_W'(1);
  end

endmodule

// ----- src/stepper_step_and_microstep_sequencer.sv -----
// top level of the two-coil stepper sequencer: handshakes, state and result register
// depends on ssms_pkg, ssms_step_rom and ssms_ramp
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser req_type, tdata move_count, tick_counter
//  m_*       out  m_tvalid/m_tready    tuser drive_mode, tdata phase, duties, count, busy
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data microstep_division
//
// every word gives exactly one result word, via the input and result registers
// a word moves from the input register into the result register and updates the
// sequencer state at the same edge; one word per cycle is sustained while m_tready is high
// that path runs through the 16x9 count scaling, then decrement and zero check
// rst is synchronous; it clears control state, sets division to 16 and duties to 1,0,0,full
// when m_tready is low the result register holds and the input register fills, then
// s_tready drops; cfg_ready is always high
module stepper_step_and_microstep_sequencer import ssms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // move_count, tick_counter
  input  logic [1:0]       s_tuser,   // req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [87:0]      m_tdata,   // coil_phase, duty_ch1..4, steps_left, busy_res, pad
  output logic [1:0]       m_tuser,   // drive_mode
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [DIV_W-1:0] cfg_data   // microstep_division
);

  // configuration
  logic [DIV_W-1:0]  division;

  // input register
  logic              in_valid;
  logic [1:0]        in_req;
  logic [CNT_W-1:0]  in_count;
  logic [TICK_W-1:0] in_tick;

  // sequencer state
  logic [CNT_W-1:0]  remaining;
  logic [DIV_W-1:0]  active_mode;
  logic [TICK_W-1:0] last_full_tick;
  logic [TICK_W-1:0] last_micro_tick;
  logic [IDX_W-1:0]  micro_index;
  logic [1:0]        phase_reg;
  duty_vec_t         duty_acc;
  logic              micro_kind;

  logic [CNT_W-1:0]  remaining_next;
  logic [DIV_W-1:0]  active_mode_next;
  logic [TICK_W-1:0] last_full_tick_next;
  logic [TICK_W-1:0] last_micro_tick_next;
  logic [IDX_W-1:0]  micro_index_next;
  logic [1:0]        phase_reg_next;
  duty_vec_t         duty_acc_next;
  logic              micro_kind_next;

  // result register
  logic [1:0]        out_phase;
  duty_vec_t         out_duty;
  logic [CNT_W-1:0]  out_steps;
  logic              out_busy;
  logic [1:0]        out_drive;
  logic [1:0]        drive_next;

  logic                    advance;
  logic [DIV_W-1:0]        div_eff;
  logic [DUTY_W-1:0]       step_add;
  ramp_t                   ramp;
  logic [CNT_W+DIV_W-1:0]  product;
  logic [CNT_W-1:0]        scaled;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // a zero division acts as one, anything above the table as its top
  always_comb begin
    if (division == '0)                      div_eff = DIV_W'(1);
    else if (division > DIV_W'(MAX_DIV))     div_eff = DIV_W'(MAX_DIV);
    else                                     div_eff = division;
  end

  ssms_step_rom u_rom (
    .div (div_eff),
    .add (step_add)
  );

  ssms_ramp u_ramp (
    .index   (micro_index),
    .div     (div_eff),
    .add     (step_add),
    .duty_in (duty_acc),
    .ramp    (ramp)
  );

  // count rescaled to microsteps when the division in use changes, saturating
  assign product = (CNT_W+DIV_W)'(remaining) * (CNT_W+DIV_W)'(div_eff);
  assign scaled  = (|product[CNT_W+DIV_W-1:CNT_W]) ? '1 : product[CNT_W-1:0];

  always_comb begin
    remaining_next       = remaining;
    active_mode_next     = active_mode;
    last_full_tick_next  = last_full_tick;
    last_micro_tick_next = last_micro_tick;
    micro_index_next     = micro_index;
    phase_reg_next       = phase_reg;
    duty_acc_next        = duty_acc;
    micro_kind_next      = micro_kind;

    case (in_req)
      REQ_LOAD: begin
        remaining_next = in_count;
      end
      REQ_FULL: begin
        if (remaining != '0) begin
          active_mode_next = MODE_FULL;
          micro_kind_next  = 1'b0;
          if (in_tick != last_full_tick) begin
            last_full_tick_next = in_tick;
            phase_reg_next      = in_tick[1:0] - 2'd1;
            remaining_next      = remaining - CNT_W'(1);
          end
        end
      end
      REQ_MICRO: begin
        if (remaining != '0) begin
          micro_kind_next  = 1'b1;
          active_mode_next = div_eff;
          remaining_next   = (active_mode != div_eff) ? scaled : remaining;
          if (in_tick != last_micro_tick) begin
            last_micro_tick_next = in_tick;
            micro_index_next     = ramp.index;
            remaining_next       = remaining_next - CNT_W'(1);
            // move finished: back to the holding duties
            duty_acc_next        = (remaining_next == '0) ? DUTY_RESET : ramp.duty;
          end
        end
      end
      default: begin
      end
    endcase

    if (remaining_next == '0) active_mode_next = MODE_IDLE;

    if (active_mode_next == MODE_IDLE) drive_next = DRV_IDLE;
    else if (micro_kind_next)          drive_next = DRV_MICRO;
    else                               drive_next = DRV_FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      division <= DIV_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      division <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req   <= s_tuser;
      in_count <= s_tdata[CNT_W-1:0];
      in_tick  <= s_tdata[CNT_W+TICK_W-1:CNT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining       <= '0;
      active_mode     <= MODE_IDLE;
      last_full_tick  <= '0;
      last_micro_tick <= '0;
      micro_index     <= '0;
      phase_reg       <= '0;
      duty_acc        <= DUTY_RESET;
      micro_kind      <= 1'b0;
    end else if (in_valid && advance) begin
      remaining       <= remaining_next;
      active_mode     <= active_mode_next;
      last_full_tick  <= last_full_tick_next;
      last_micro_tick <= last_micro_tick_next;
      micro_index     <= micro_index_next;
      phase_reg       <= phase_reg_next;
      duty_acc        <= duty_acc_next;
      micro_kind      <= micro_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_phase <= phase_reg_next;
      out_duty  <= duty_acc_next;
      out_steps <= remaining_next;
      out_busy  <= (remaining_next != '0);
      out_drive <= drive_next;
    end
  end

  assign m_tdata = {5'b00000, out_busy, out_steps, out_duty[3], out_duty[2], out_duty[1],
                    out_duty[0], out_phase};
  assign m_tuser = out_drive;

`ifndef NO_ASSERTIONS
  // an empty count always leaves the sequencer idle
  a_idle_at_zero: assert property (@(posedge clk) disable iff (rst)
    (remaining == '0) |-> (active_mode == MODE_IDLE))
    else $error("sequencer not idle with zero count");

  // busy flag follows the reported count, and a zero count reports idle
  a_busy_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_busy == (out_steps != '0)) &&
                  ((out_steps != '0) || (out_drive == DRV_IDLE))))
    else $error("busy or drive mode disagrees with steps left");

  // state only moves when a word passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && advance) |=> ($stable(remaining) && $stable(duty_acc) &&
                                $stable(micro_index)))
    else $error("sequencer state changed without a word");
`endif

endmodule
